FILE: hw/rtl/timer_bank_one_shot_periodic_macros.svh
// Assertion macros for the timer bank.
// Used by the top level; no other dependencies.
`ifndef TIMER_BANK_ONE_SHOT_PERIODIC_MACROS_SVH
`define TIMER_BANK_ONE_SHOT_PERIODIC_MACROS_SVH
`ifndef ASSERT_OFF
`define TBO_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tbo assertion failed");
`define TBO_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("tbo forbidden condition");
`else
`define TBO_ASSERT(lbl, clk, rstn, prop)
`define TBO_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

FILE: hw/rtl/tbo_pkg.sv
// Shared constants, codes and types of the timer bank.
// No dependencies.
package tbo_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int SEL_W      = 7;

  localparam logic [1:0] CMD_ARM      = 2'd0;
  localparam logic [1:0] CMD_STOP     = 2'd1;
  localparam logic [1:0] CMD_STOP_ALL = 2'd2;
  localparam logic [1:0] CMD_SCAN     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } tbo_state_e;

  typedef struct packed {
    logic        arm;
    logic        stop;
    logic        stop_all;
    logic        adv;
    logic        repeating;
    logic [30:0] timeout;
    logic [31:0] now;
  } tbo_cell_ctrl_t;

endpackage

FILE: hw/rtl/timer_bank_one_shot_periodic.sv
// Timer bank top level: command decode, scan token control, result register.
// Arm, stop and stop-all give their single word in the cycle after acceptance.
// A scan walks the chain of timer cells one cell per cycle while the output register is free;
// its last word is registered from state ST_FIN.
// The next word is accepted once the previous one has finished and the output
// register is free. Reset stops all timers and clears deadline and period.
`include "timer_bank_one_shot_periodic_macros.svh"
module timer_bank_one_shot_periodic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  timer_index_i,
  input  logic [30:0] timeout_i,
  input  logic        repeating_i,
  input  logic [31:0] now_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic        fired_o,
  output logic [3:0]  fired_index_o,
  output logic        last_o
);

  localparam int N = tbo_pkg::NUM_TIMERS;
  localparam int W = tbo_pkg::IDX_W;

  tbo_pkg::tbo_state_e     state_q, state_d;
  tbo_pkg::tbo_cell_ctrl_t ctrl;

  logic [W-1:0]   idx_q;
  logic [31:0]    now_q;
  logic           pend_v_q;
  logic [3:0]     pend_idx_q;
  logic           out_valid_q, status_q, fired_q, last_q;
  logic [3:0]     fired_index_q;

  logic [N-1:0]   sel, running, fire, tok;
  logic           accept, ok_load, adv, start, any_fire, busy, fin_go;
  logic [W+3:0]   idx_ext;
  logic [3:0]     idx4;

  assign ok_load    = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == tbo_pkg::ST_IDLE) && ok_load;
  assign accept     = in_valid_i && in_ready_o;
  assign start      = accept && (cmd_i == tbo_pkg::CMD_SCAN);
  assign adv        = (state_q == tbo_pkg::ST_SCAN) && ok_load;
  assign fin_go     = (state_q == tbo_pkg::ST_FIN) && ok_load;
  assign any_fire   = |fire;
  assign busy       = |(sel & running);
  assign idx_ext    = {4'b0, idx_q};
  assign idx4       = idx_ext[3:0];

  always_comb begin
    ctrl.arm       = accept && (cmd_i == tbo_pkg::CMD_ARM);
    ctrl.stop      = accept && (cmd_i == tbo_pkg::CMD_STOP);
    ctrl.stop_all  = accept && (cmd_i == tbo_pkg::CMD_STOP_ALL);
    ctrl.adv       = adv;
    ctrl.repeating = repeating_i;
    ctrl.timeout   = timeout_i;
    ctrl.now       = (state_q == tbo_pkg::ST_SCAN) ? now_q : now_i;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign sel[i] = ({3'b0, timer_index_i} == tbo_pkg::SEL_W'(i));
    tbo_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .sel_i      (sel[i]),
      .tok_load_i (start || adv),
      .tok_i      ((i == 0) ? start : tok[(i == 0) ? 0 : i - 1]),
      .tok_o      (tok[i]),
      .running_o  (running[i]),
      .fire_o     (fire[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tbo_pkg::ST_IDLE: if (start) state_d = tbo_pkg::ST_SCAN;
      tbo_pkg::ST_SCAN: if (adv && (idx_q == W'(N - 1))) state_d = tbo_pkg::ST_FIN;
      tbo_pkg::ST_FIN:  if (ok_load) state_d = tbo_pkg::ST_IDLE;
      default:          state_d = tbo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbo_pkg::ST_IDLE;
      idx_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start) begin
        idx_q    <= '0;
        pend_v_q <= 1'b0;
      end else if (adv) begin
        idx_q <= idx_q + W'(1);
        if (any_fire) begin
          pend_v_q <= 1'b1;
        end
      end else if (fin_go) begin
        pend_v_q <= 1'b0;
      end
      if ((accept && !start) || (adv && any_fire && pend_v_q) || fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      now_q <= now_i;
    end
    if (adv && any_fire) begin
      pend_idx_q <= idx4;
    end
    if (accept && !start) begin
      status_q      <= (cmd_i == tbo_pkg::CMD_ARM) && busy;
      fired_q       <= 1'b0;
      fired_index_q <= 4'd0;
      last_q        <= 1'b1;
    end else if (adv && any_fire && pend_v_q) begin
      status_q      <= 1'b0;
      fired_q       <= 1'b1;
      fired_index_q <= pend_idx_q;
      last_q        <= 1'b0;
    end else if (fin_go) begin
      status_q      <= 1'b0;
      fired_q       <= pend_v_q;
      fired_index_q <= pend_v_q ? pend_idx_q : 4'd0;
      last_q        <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign fired_o       = fired_q;
  assign fired_index_o = fired_index_q;
  assign last_o        = last_q;

  `TBO_ASSERT(a_tok_onehot0, clk_i, rst_ni, $onehot0(tok))
  `TBO_ASSERT(a_fire_scan, clk_i, rst_ni, (|fire) |-> (state_q == tbo_pkg::ST_SCAN))
  `TBO_ASSERT_NEVER(a_ready_pend, clk_i, rst_ni, in_ready_o && pend_v_q)
  `TBO_ASSERT(a_nonlast_busy, clk_i, rst_ni,
              (out_valid_o && !last_o) |-> (state_q != tbo_pkg::ST_IDLE))

endmodule

FILE: hw/rtl/tbo_cell.sv
// One timer of the bank: deadline, period and flags, plus the scan token.
// Depends on tbo_pkg.
module tbo_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tbo_pkg::tbo_cell_ctrl_t ctrl_i,
  input  logic                    sel_i,
  input  logic                    tok_load_i,
  input  logic                    tok_i,
  output logic                    tok_o,
  output logic                    running_o,
  output logic                    fire_o
);

  logic [31:0] deadline_q, deadline_d;
  logic [30:0] period_q, period_d;
  logic        running_q, running_d;
  logic        periodic_q, periodic_d;
  logic        tok_q;
  logic [31:0] diff;
  logic        due;

  assign diff   = ctrl_i.now - deadline_q;
  assign due    = ~diff[31];
  assign fire_o = tok_q & ctrl_i.adv & running_q & due;

  always_comb begin
    deadline_d = deadline_q;
    period_d   = period_q;
    running_d  = running_q;
    periodic_d = periodic_q;
    if (fire_o) begin
      if (periodic_q) begin
        deadline_d = deadline_q + {1'b0, period_q};
      end else begin
        running_d = 1'b0;
      end
    end
    if (ctrl_i.arm && sel_i && !running_q) begin
      deadline_d = ctrl_i.now + {1'b0, ctrl_i.timeout};
      period_d   = ctrl_i.timeout;
      periodic_d = ctrl_i.repeating;
      running_d  = 1'b1;
    end
    if ((ctrl_i.stop && sel_i) || ctrl_i.stop_all) begin
      running_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= '0;
      period_q   <= '0;
      running_q  <= 1'b0;
      periodic_q <= 1'b0;
      tok_q      <= 1'b0;
    end else begin
      deadline_q <= deadline_d;
      period_q   <= period_d;
      running_q  <= running_d;
      periodic_q <= periodic_d;
      if (tok_load_i) begin
        tok_q <= tok_i;
      end
    end
  end

  assign tok_o     = tok_q;
  assign running_o = running_q;

endmodule

FILE: tb/tb_timer_bank_one_shot_periodic.sv
// Self-checking testbench for timer_bank_one_shot_periodic: arm, stop, stop-all and scan words
// are predicted in place and every output word is compared field by field.
// Depends on tbo_pkg and the top level of the timer bank.
module tb_timer_bank_one_shot_periodic;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int N_WORDS      = 430;
  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  idx;
    logic [30:0] timeout;
    logic        repeating;
    logic [31:0] now;
  } timer_cmd_t;

  typedef struct packed {
    logic       status;
    logic       fired;
    logic [3:0] fired_index;
    logic       last;
  } timer_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i         = tbo_pkg::CMD_ARM;
  logic [3:0]  timer_index_i = '0;
  logic [30:0] timeout_i     = '0;
  logic        repeating_i   = 1'b0;
  logic [31:0] now_i         = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic        status_o;
  logic        fired_o;
  logic [3:0]  fired_index_o;
  logic        last_o;

  timer_cmd_t    cmd_word_q[$];
  timer_result_t result_word_q[$];
  timer_cmd_t    next_word;
  timer_result_t want;

  logic [31:0] tmr_deadline [tbo_pkg::NUM_TIMERS];
  logic [30:0] tmr_period   [tbo_pkg::NUM_TIMERS];
  logic        tmr_running  [tbo_pkg::NUM_TIMERS];
  logic        tmr_periodic [tbo_pkg::NUM_TIMERS];

  logic        in_word_taken = 1'b0;
  logic        hold_off      = 1'b0;
  int          words_in      = 0;
  int          n_words       = 0;
  int          mismatch_cnt  = 0;
  int          cycle_cnt     = 0;
  int          gap_left      = 0;
  int          burst_left    = 8;
  int          mode_left     = 0;
  int          stall_mode    = 0;
  logic [7:0]  stall_pattern = 8'hFF;

  timer_bank_one_shot_periodic dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .timer_index_i (timer_index_i),
    .timeout_i     (timeout_i),
    .repeating_i   (repeating_i),
    .now_i         (now_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .fired_o       (fired_o),
    .fired_index_o (fired_index_o),
    .last_o        (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < tbo_pkg::NUM_TIMERS; i++) begin
      tmr_deadline[i] = '0;
      tmr_period[i]   = '0;
      tmr_running[i]  = 1'b0;
      tmr_periodic[i] = 1'b0;
    end
  end

  task automatic push_word(input logic [1:0] cmd, input logic [3:0] idx,
                           input logic [30:0] tmo, input logic rep, input logic [31:0] now);
    timer_cmd_t w;
    w.cmd       = cmd;
    w.idx       = idx;
    w.timeout   = tmo;
    w.repeating = rep;
    w.now       = now;
    cmd_word_q.push_back(w);
  endtask

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic apply_timer_cmd(input logic [1:0] cmd, input logic [3:0] idx,
                                 input logic [30:0] tmo, input logic rep,
                                 input logic [31:0] now);
    timer_result_t r;
    logic [31:0]   diff;
    int            hits;
    r    = '0;
    hits = 0;
    case (cmd)
      tbo_pkg::CMD_ARM: begin
        if (idx < tbo_pkg::NUM_TIMERS) begin
          if (tmr_running[idx]) begin
            r.status = 1'b1;
          end else begin
            tmr_period[idx]   = tmo;
            tmr_deadline[idx] = now + {1'b0, tmo};
            tmr_running[idx]  = 1'b1;
            tmr_periodic[idx] = rep;
          end
        end
        r.last = 1'b1;
        result_word_q.push_back(r);
      end
      tbo_pkg::CMD_STOP: begin
        if (idx < tbo_pkg::NUM_TIMERS) tmr_running[idx] = 1'b0;
        r.last = 1'b1;
        result_word_q.push_back(r);
      end
      tbo_pkg::CMD_STOP_ALL: begin
        for (int i = 0; i < tbo_pkg::NUM_TIMERS; i++) tmr_running[i] = 1'b0;
        r.last = 1'b1;
        result_word_q.push_back(r);
      end
      default: begin
        for (int i = 0; i < tbo_pkg::NUM_TIMERS && hits < 16; i++) begin
          diff = now - tmr_deadline[i];
          if (tmr_running[i] && !diff[31]) begin
            if (tmr_periodic[i]) tmr_deadline[i] = tmr_deadline[i] + {1'b0, tmr_period[i]};
            else tmr_running[i] = 1'b0;
            r.fired       = 1'b1;
            r.fired_index = 4'(i);
            result_word_q.push_back(r);
            hits++;
          end
        end
        if (hits == 0) begin
          r.last = 1'b1;
          result_word_q.push_back(r);
        end else begin
          result_word_q[result_word_q.size() - 1].last = 1'b1;
        end
      end
    endcase
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_word_q.size() > 0) begin
        next_word = cmd_word_q.pop_front();
        cmd_i         <= next_word.cmd;
        timer_index_i <= next_word.idx;
        timeout_i     <= next_word.timeout;
        repeating_i   <= next_word.repeating;
        now_i         <= next_word.now;
        in_valid_i    <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode    = $urandom_range(0, 3);
        mode_left     = $urandom_range(16, 120);
        stall_pattern = 8'($urandom);
      end else begin
        mode_left--;
      end
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= stall_pattern[0];
        endcase
      end
    end
  end

  // hold the output off for a long stretch so the input side backs up
  initial begin
    @(posedge clk_i);
    while (words_in < 80) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_word_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        apply_timer_cmd(cmd_i, timer_index_i, timeout_i, repeating_i, now_i);
        words_in <= words_in + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (result_word_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected word status=%0b fired=%0b index=%0d last=%0b",
                                  status_o, fired_o, fired_index_o, last_o));
        end else begin
          want = result_word_q.pop_front();
          if (status_o !== want.status)
            flag_mismatch($sformatf("status %0b, want %0b", status_o, want.status));
          if (fired_o !== want.fired)
            flag_mismatch($sformatf("fired %0b, want %0b", fired_o, want.fired));
          if (fired_index_o !== want.fired_index)
            flag_mismatch($sformatf("fired_index %0d, want %0d", fired_index_o,
                                    want.fired_index));
          if (last_o !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [31:0] tick;
    int          pick;

    push_word(tbo_pkg::CMD_SCAN,     4'd0,  31'd0,          1'b0, 32'd0);
    push_word(tbo_pkg::CMD_STOP,     4'd0,  31'd0,          1'b0, 32'd0);
    push_word(tbo_pkg::CMD_ARM,      4'd0,  31'd0,          1'b0, 32'd0);
    push_word(tbo_pkg::CMD_ARM,      4'd0,  31'd5,          1'b0, 32'd0);
    push_word(tbo_pkg::CMD_SCAN,     4'd0,  31'd0,          1'b0, 32'd0);
    push_word(tbo_pkg::CMD_SCAN,     4'd0,  31'd0,          1'b0, 32'd0);
    push_word(tbo_pkg::CMD_ARM,      4'd15, 31'h7FFF_FFFF,  1'b1, 32'hFFFF_FFFF);
    push_word(tbo_pkg::CMD_ARM,      4'd1,  31'd5,          1'b1, 32'd10);
    push_word(tbo_pkg::CMD_ARM,      4'd2,  31'd3,          1'b0, 32'd10);
    push_word(tbo_pkg::CMD_SCAN,     4'd0,  31'd0,          1'b0, 32'd12);
    push_word(tbo_pkg::CMD_SCAN,     4'd0,  31'd0,          1'b0, 32'd15);
    push_word(tbo_pkg::CMD_SCAN,     4'd0,  31'd0,          1'b0, 32'd20);
    push_word(tbo_pkg::CMD_SCAN,     4'd0,  31'd0,          1'b0, 32'h7FFF_FFFD);
    push_word(tbo_pkg::CMD_SCAN,     4'd0,  31'd0,          1'b0, 32'h7FFF_FFFE);
    push_word(tbo_pkg::CMD_STOP,     4'd1,  31'h7FFF_FFFF,  1'b1, 32'd0);
    push_word(tbo_pkg::CMD_ARM,      4'd14, 31'd1,          1'b0, 32'hFFFF_FFFF);
    push_word(tbo_pkg::CMD_SCAN,     4'd15, 31'h7FFF_FFFF,  1'b1, 32'hFFFF_FFFF);
    push_word(tbo_pkg::CMD_SCAN,     4'd0,  31'd0,          1'b0, 32'd0);
    push_word(tbo_pkg::CMD_ARM,      4'd3,  31'd100,        1'b1, 32'd0);
    push_word(tbo_pkg::CMD_STOP_ALL, 4'd0,  31'd0,          1'b0, 32'd0);
    push_word(tbo_pkg::CMD_SCAN,     4'd0,  31'd0,          1'b0, 32'd1000);
    push_word(tbo_pkg::CMD_ARM,      4'd3,  31'd0,          1'b1, 32'd5);
    push_word(tbo_pkg::CMD_SCAN,     4'd0,  31'd0,          1'b0, 32'd5);
    push_word(tbo_pkg::CMD_SCAN,     4'd0,  31'd0,          1'b0, 32'd5);

    while (cmd_word_q.size() < N_WORDS - 20) begin
      tick = $urandom;
      if ($urandom_range(0, 3) == 0) tick = 32'hFFFF_FF00 + $urandom_range(0, 200);
      if ($urandom_range(0, 4) == 0) begin
        push_word(tbo_pkg::CMD_STOP_ALL, 4'($urandom), 31'($urandom), 1'($urandom), tick);
        for (int i = 0; i < tbo_pkg::NUM_TIMERS; i++)
          push_word(tbo_pkg::CMD_ARM, 4'(i), 31'($urandom_range(0, 3)), 1'($urandom), tick);
        push_word(tbo_pkg::CMD_SCAN, 4'($urandom), 31'($urandom), 1'($urandom), tick + 4);
        push_word(tbo_pkg::CMD_SCAN, 4'($urandom), 31'($urandom), 1'($urandom),
                  tick + $urandom_range(0, 8));
      end
      repeat ($urandom_range(20, 50)) begin
        tick = tick + $urandom_range(0, 6);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          push_word(2'($urandom), 4'($urandom), 31'($urandom), 1'($urandom), $urandom);
        end else if (pick < 45) begin
          push_word(tbo_pkg::CMD_ARM, 4'($urandom),
                    ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 40)),
                    1'($urandom), tick);
        end else if (pick < 58) begin
          push_word(tbo_pkg::CMD_STOP, 4'($urandom), 31'($urandom), 1'($urandom), tick);
        end else if (pick < 61) begin
          push_word(tbo_pkg::CMD_STOP_ALL, 4'($urandom), 31'($urandom), 1'($urandom), tick);
        end else begin
          push_word(tbo_pkg::CMD_SCAN, 4'($urandom), 31'($urandom), 1'($urandom), tick);
        end
      end
    end
    n_words = cmd_word_q.size();

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (words_in != n_words || result_word_q.size() != 0) @(negedge clk_i);
    repeat (tbo_pkg::NUM_TIMERS + 8) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/tbo_pkg.sv
hw/rtl/tbo_cell.sv
hw/rtl/timer_bank_one_shot_periodic.sv
tb/tb_timer_bank_one_shot_periodic.sv
